[rtl/core/drs_pkg.sv]
// ----------------------------------------------------------------------------
// Disk request scheduler package
// Shared types, codes and default sizes for the scheduler and its queue cells.
// ----------------------------------------------------------------------------
package drs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int ID_W   = 16;
	localparam int TIME_W = 32;
	localparam int CYL_W  = 16;
	localparam int ADDR_W = 32;
	localparam int PROC_W = 16;

	localparam logic POLICY_FCFS = 1'b0;
	localparam logic POLICY_SSTF = 1'b1;

	localparam logic FUNC_ARRIVE   = 1'b0;
	localparam logic FUNC_COMPLETE = 1'b1;

	// One request as it sits in the queue or in the served slot.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] tstamp;
		logic [CYL_W-1:0]  cyl;
		logic [ADDR_W-1:0] addr;
		logic [PROC_W-1:0] proc_id;
	} entry_t;

	// Best candidate so far, handed from cell to cell during a scan.
	typedef struct packed {
		logic             valid;
		logic [CYL_W-1:0] seek_len;
		entry_t           entry;
	} cand_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic load;
		logic shift;
		logic occupied;
		logic scan_en;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_RESULT
	} state_t;

endpackage

[rtl/core/drs_cell.sv]
// ----------------------------------------------------------------------------
// Queue cell
// Holds one pending request, shifts toward the head of the queue on removal
// and compares itself against the candidate handed in by its left neighbor.
// ----------------------------------------------------------------------------
module drs_cell import drs_pkg::*; #(
	parameter int POS_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [POS_W-1:0] cell_pos,
	input  logic             policy,
	input  logic [CYL_W-1:0] head,
	input  entry_t           load_entry,
	input  entry_t           right_entry,
	output entry_t           entry,
	input  cand_t            cand_in,
	input  logic [POS_W-1:0] cand_pos_in,
	output cand_t            cand_out,
	output logic [POS_W-1:0] cand_pos_out
);

	entry_t           entry_q;
	cand_t            cand_q;
	logic [POS_W-1:0] cand_pos_q;
	logic [CYL_W-1:0] seek_len;
	logic             better;
	logic             take;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= load_entry;
		end else if (ctl.shift) begin
			entry_q <= right_entry;
		end
	end

	assign seek_len = (entry_q.cyl >= head) ? (entry_q.cyl - head) : (head - entry_q.cyl);

	// Strictly better only, so the earlier position keeps ties.
	always_comb begin
		if (policy == POLICY_SSTF) begin
			better = (seek_len < cand_in.seek_len) ||
				((seek_len == cand_in.seek_len) && (entry_q.tstamp < cand_in.entry.tstamp));
		end else begin
			better = entry_q.tstamp < cand_in.entry.tstamp;
		end
		take = ctl.occupied && (!cand_in.valid || better);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q     <= '0;
			cand_pos_q <= '0;
		end else if (ctl.scan_en) begin
			cand_q.valid <= take || cand_in.valid;
			if (take) begin
				cand_q.seek_len <= seek_len;
				cand_q.entry    <= entry_q;
				cand_pos_q      <= cell_pos;
			end else begin
				cand_q.seek_len <= cand_in.seek_len;
				cand_q.entry    <= cand_in.entry;
				cand_pos_q      <= cand_pos_in;
			end
		end
	end

	assign entry        = entry_q;
	assign cand_out     = cand_q;
	assign cand_pos_out = cand_pos_q;

endmodule

[rtl/core/disk_request_scheduler_top.sv]
// ----------------------------------------------------------------------------
// Disk request scheduler, top level
// Served request slot, a chain of queue cells and the sequencer around them.
// ----------------------------------------------------------------------------
// Items enter on the in_valid/in_stall channel; a transfer happens when
// in_valid is high and in_stall is low. func selects an arrival or the
// completion of the served request. Every item gives exactly one result on
// the out_valid/out_stall channel: the request served afterwards and the
// dropped flag of an arrival that found the queue full.
// An arrival, or a completion on an empty queue, goes straight from the
// idle state to the result state; a completion on a non-empty queue
// first passes the scan and pick states: the best-candidate token walks
// the chain one cell per cycle, then the winner is removed in the pick
// state while the cells behind it shift forward. The result state loads the
// output register once it is free, and the sequencer then turns idle.
// A new item is taken as soon as the sequencer is idle again, even while
// the previous result still waits in the output register.
// When the receiver stalls, the result is held and the next result waits
// for the output register, which holds in_stall high meanwhile.
// Reset empties the queue, idles the disk and selects first come first
// served. The policy register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module disk_request_scheduler_top import drs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [ID_W-1:0]   req_id,
	input  logic [TIME_W-1:0] arrival_time,
	input  logic [CYL_W-1:0]  cylinder,
	input  logic [ADDR_W-1:0] block_address,
	input  logic [PROC_W-1:0] req_process,
	input  logic [CYL_W-1:0]  head_cylinder,

	output logic              out_valid,
	input  logic              out_stall,
	output logic              has_request,
	output logic [ID_W-1:0]   out_id,
	output logic [TIME_W-1:0] out_time,
	output logic [CYL_W-1:0]  out_cylinder,
	output logic [ADDR_W-1:0] out_address,
	output logic [PROC_W-1:0] out_process,
	output logic              dropped
);

	localparam int POS_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	state_t           state_q;
	state_t           state_nxt;
	logic             policy_q;
	logic [CNT_W-1:0] count_q;
	logic [POS_W-1:0] scan_cnt_q;
	logic [CYL_W-1:0] head_q;
	logic             serving_valid_q;
	entry_t           serving_q;
	logic             drop_q;
	logic             out_valid_q;
	entry_t           out_entry_q;
	logic             out_has_q;
	logic             out_drop_q;

	logic             accept;
	logic             cfg_wr;
	logic             out_free;
	logic             queue_full;
	logic             enqueue;
	entry_t           in_entry;

	cell_ctl_t        ctl [QUEUE_DEPTH];
	entry_t           cell_entry [QUEUE_DEPTH];
	cand_t            cand [QUEUE_DEPTH];
	logic [POS_W-1:0] cand_pos [QUEUE_DEPTH];
	cand_t            cand_first;
	cand_t            win;
	logic [POS_W-1:0] win_pos;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {31'b0, policy_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_FCFS;
		end else if (cfg_wr) begin
			policy_q <= pwdata[0];
		end
	end

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign queue_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign enqueue    = accept && (func == FUNC_ARRIVE) && serving_valid_q && !queue_full;

	assign in_entry.id      = req_id;
	assign in_entry.tstamp  = arrival_time;
	assign in_entry.cyl     = cylinder;
	assign in_entry.addr    = block_address;
	assign in_entry.proc_id = req_process;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((func == FUNC_COMPLETE) && (count_q != '0)) begin
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = ST_RESULT;
					end
				end
			end
			ST_SCAN: begin
				if (scan_cnt_q == POS_W'(QUEUE_DEPTH - 1)) begin
					state_nxt = ST_PICK;
				end
			end
			ST_PICK: begin
				state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_cnt_q <= scan_cnt_q + 1'b1;
		end else begin
			scan_cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_q <= head_cylinder;
		end
	end

	// Served slot, queue fill count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serving_valid_q <= 1'b0;
			serving_q       <= '0;
			count_q         <= '0;
			drop_q          <= 1'b0;
		end else if (accept) begin
			drop_q <= 1'b0;
			if (func == FUNC_ARRIVE) begin
				if (!serving_valid_q) begin
					serving_valid_q <= 1'b1;
					serving_q       <= in_entry;
				end else if (queue_full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end else if (count_q == '0) begin
				serving_valid_q <= 1'b0;
				serving_q       <= '0;
			end
		end else if (state_q == ST_PICK) begin
			serving_valid_q <= 1'b1;
			serving_q       <= win.entry;
			count_q         <= count_q - 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			out_entry_q <= serving_q;
			out_has_q   <= serving_valid_q;
			out_drop_q  <= drop_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign has_request  = out_has_q;
	assign out_id       = out_entry_q.id;
	assign out_time     = out_entry_q.tstamp;
	assign out_cylinder = out_entry_q.cyl;
	assign out_address  = out_entry_q.addr;
	assign out_process  = out_entry_q.proc_id;
	assign dropped      = out_drop_q;

	// Chain of queue cells; the first cell sees an empty candidate.
	assign cand_first = '0;
	assign win        = cand[QUEUE_DEPTH-1];
	assign win_pos    = cand_pos[QUEUE_DEPTH-1];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t           right;
		cand_t            left_cand;
		logic [POS_W-1:0] left_pos;

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right = cell_entry[i];
		end else begin : g_mid
			assign right = cell_entry[i+1];
		end

		if (i == 0) begin : g_first
			assign left_cand = cand_first;
			assign left_pos  = '0;
		end else begin : g_rest
			assign left_cand = cand[i-1];
			assign left_pos  = cand_pos[i-1];
		end

		assign ctl[i].load     = enqueue && (count_q == CNT_W'(i));
		assign ctl[i].shift    = (state_q == ST_PICK) && (POS_W'(i) >= win_pos);
		assign ctl[i].occupied = (count_q > CNT_W'(i));
		assign ctl[i].scan_en  = (state_q == ST_SCAN);

		drs_cell #(
			.POS_W(POS_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl[i]),
			.cell_pos     (POS_W'(i)),
			.policy       (policy_q),
			.head         (head_q),
			.load_entry   (in_entry),
			.right_entry  (right),
			.entry        (cell_entry[i]),
			.cand_in      (left_cand),
			.cand_pos_in  (left_pos),
			.cand_out     (cand[i]),
			.cand_pos_out (cand_pos[i])
		);
	end

endmodule

[tb/drs_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Disk request scheduler testbench support
// Item and result types and a mirror of the scheduler's state. The mirror
// computes the served request after each accepted item and checks the
// results that the scheduler produces against it, in order.
// ----------------------------------------------------------------------------
package drs_tb_pkg;

	import drs_pkg::*;

	typedef struct packed {
		logic             func;
		entry_t           req;
		logic [CYL_W-1:0] head;
	} sched_item_t;

	typedef struct packed {
		logic   busy;
		entry_t req;
		logic   dropped;
	} served_t;

	class disk_queue_mirror;
		logic      policy;
		logic      busy;
		entry_t    current;
		entry_t    pending_q[$];
		served_t   served_due[$];
		int        errors;

		function new();
			policy  = POLICY_FCFS;
			busy    = 1'b0;
			current = '0;
			errors  = 0;
		endfunction

		function void set_policy(logic p);
			policy = p;
		endfunction

		function int unsigned outstanding();
			return served_due.size();
		endfunction

		function void report(string what, logic [63:0] want, logic [63:0] got);
			errors++;
			if (errors <= 10) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			end
		endfunction

		function logic [CYL_W-1:0] seek(logic [CYL_W-1:0] a, logic [CYL_W-1:0] b);
			return (a >= b) ? a - b : b - a;
		endfunction

		// Position of the next request to serve; ties keep the lowest position.
		function int unsigned choose(logic [CYL_W-1:0] head);
			int unsigned best;
			int unsigned i;
			logic [CYL_W-1:0] di;
			logic [CYL_W-1:0] db;
			logic better;
			best = 0;
			for (i = 1; i < pending_q.size(); i++) begin
				if (policy == POLICY_FCFS) begin
					better = pending_q[i].tstamp < pending_q[best].tstamp;
				end else begin
					di = seek(pending_q[i].cyl, head);
					db = seek(pending_q[best].cyl, head);
					better = (di < db) ||
						(di == db && pending_q[i].tstamp < pending_q[best].tstamp);
				end
				if (better) begin
					best = i;
				end
			end
			return best;
		endfunction

		function void absorb_item(sched_item_t it);
			served_t s;
			int unsigned pos;
			s.dropped = 1'b0;
			if (it.func == FUNC_ARRIVE) begin
				if (!busy) begin
					busy    = 1'b1;
					current = it.req;
				end else if (pending_q.size() >= QUEUE_DEPTH_DEF) begin
					s.dropped = 1'b1;
				end else begin
					pending_q.push_back(it.req);
				end
			end else if (pending_q.size() == 0) begin
				busy    = 1'b0;
				current = '0;
			end else begin
				pos     = choose(it.head);
				current = pending_q[pos];
				busy    = 1'b1;
				pending_q.delete(pos);
			end
			s.busy = busy;
			s.req  = busy ? current : '0;
			served_due.push_back(s);
		endfunction

		function void check_served(served_t got);
			served_t want;
			if (served_due.size() == 0) begin
				report("unexpected result, has_request", 64'h0, 64'(got.busy));
				return;
			end
			want = served_due.pop_front();
			if (got.busy !== want.busy)
				report("has_request", 64'(want.busy), 64'(got.busy));
			if (got.req.id !== want.req.id)
				report("out_id", 64'(want.req.id), 64'(got.req.id));
			if (got.req.tstamp !== want.req.tstamp)
				report("out_time", 64'(want.req.tstamp), 64'(got.req.tstamp));
			if (got.req.cyl !== want.req.cyl)
				report("out_cylinder", 64'(want.req.cyl), 64'(got.req.cyl));
			if (got.req.addr !== want.req.addr)
				report("out_address", 64'(want.req.addr), 64'(got.req.addr));
			if (got.req.proc_id !== want.req.proc_id)
				report("out_process", 64'(want.req.proc_id), 64'(got.req.proc_id));
			if (got.dropped !== want.dropped)
				report("dropped", 64'(want.dropped), 64'(got.dropped));
		endfunction
	endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Disk request scheduler testbench
// Drives arrivals and completions under both selection policies, with random
// gaps and stalls on both channels, and checks every served request.
// ----------------------------------------------------------------------------
module tb;

	import drs_pkg::*;
	import drs_tb_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam logic [2:0] REG_POLICY = 3'd0;
	localparam logic [2:0] REG_UNUSED = 3'd4;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              func = FUNC_ARRIVE;
	logic [ID_W-1:0]   req_id = '0;
	logic [TIME_W-1:0] arrival_time = '0;
	logic [CYL_W-1:0]  cylinder = '0;
	logic [ADDR_W-1:0] block_address = '0;
	logic [PROC_W-1:0] req_process = '0;
	logic [CYL_W-1:0]  head_cylinder = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              has_request;
	logic [ID_W-1:0]   out_id;
	logic [TIME_W-1:0] out_time;
	logic [CYL_W-1:0]  out_cylinder;
	logic [ADDR_W-1:0] out_address;
	logic [PROC_W-1:0] out_process;
	logic              dropped;

	disk_queue_mirror mirror;
	int               hold_cycles = 0;
	bit               sender_gaps = 1'b1;
	bit               drain_gaps = 1'b1;
	logic [TIME_W-1:0] stamp = '0;

	disk_request_scheduler_top #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.req_id(req_id), .arrival_time(arrival_time), .cylinder(cylinder),
		.block_address(block_address), .req_process(req_process),
		.head_cylinder(head_cylinder),
		.out_valid(out_valid), .out_stall(out_stall), .has_request(has_request),
		.out_id(out_id), .out_time(out_time), .out_cylinder(out_cylinder),
		.out_address(out_address), .out_process(out_process), .dropped(dropped)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			mirror.absorb_item({func, req_id, arrival_time, cylinder, block_address,
				req_process, head_cylinder});
		end
		if (arst_n && out_valid && !out_stall) begin
			mirror.check_served({has_request, out_id, out_time, out_cylinder, out_address,
				out_process, dropped});
		end
	end

	// Receiver: a random stall before each result transfer, or a long hold-off
	// when one is requested.
	initial begin
		int w;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				w = hold_cycles;
				hold_cycles = 0;
			end else begin
				w = drain_gaps ? $urandom_range(0, 16) : 0;
			end
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic logic [15:0] rand16();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand32();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic sched_item_t arrival(logic [ID_W-1:0] id, logic [TIME_W-1:0] tm,
			logic [CYL_W-1:0] cyl, logic [ADDR_W-1:0] addr, logic [PROC_W-1:0] pid);
		sched_item_t it;
		it.func        = FUNC_ARRIVE;
		it.req.id      = id;
		it.req.tstamp  = tm;
		it.req.cyl     = cyl;
		it.req.addr    = addr;
		it.req.proc_id = pid;
		it.head        = rand16();
		return it;
	endfunction

	function automatic sched_item_t completion(logic [CYL_W-1:0] head);
		sched_item_t it;
		it      = arrival(rand16(), rand32(), rand16(), rand32(), rand16());
		it.func = FUNC_COMPLETE;
		it.head = head;
		return it;
	endfunction

	// Time modes: 0 spread over the whole range, 1 a few values with many ties,
	// 2 a slowly rising clock. Cylinder mode 1 clusters around one cylinder so
	// that seek distances tie often.
	function automatic sched_item_t random_item(int arrive_pct, int tmode, int cmode,
			logic [CYL_W-1:0] center);
		sched_item_t it;
		it = arrival(rand16(), rand32(), rand16(), rand32(), rand16());
		if ($urandom_range(1, 100) > arrive_pct) begin
			it.func = FUNC_COMPLETE;
		end
		case (tmode)
			0: it.req.tstamp = rand32();
			1: begin
				case ($urandom_range(0, 3))
					0: it.req.tstamp = 32'h0000_0000;
					1: it.req.tstamp = 32'h0000_0001;
					2: it.req.tstamp = 32'hFFFF_FFFE;
					default: it.req.tstamp = 32'hFFFF_FFFF;
				endcase
			end
			default: begin
				stamp = stamp + $urandom_range(0, 3);
				it.req.tstamp = stamp;
			end
		endcase
		if (cmode == 1) begin
			it.req.cyl = center + 16'($urandom_range(0, 16)) - 16'd8;
			it.head    = center + 16'($urandom_range(0, 16)) - 16'd8;
		end
		return it;
	endfunction

	task automatic send_item(sched_item_t it);
		int gap;
		gap = sender_gaps ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= it.func;
		req_id        <= it.req.id;
		arrival_time  <= it.req.tstamp;
		cylinder      <= it.req.cyl;
		block_address <= it.req.addr;
		req_process   <= it.req.proc_id;
		head_cylinder <= it.head;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering items, wait for every result, then let a full scan pass.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (mirror.outstanding() != 0);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic verify_policy();
		logic [31:0] rd;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= REG_POLICY;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== 32'(mirror.policy)) begin
			mirror.report("policy readback", 64'(mirror.policy), 64'(rd));
		end
	endtask

	task automatic write_policy(logic p);
		apb_write(REG_POLICY, 32'(p));
		mirror.set_policy(p);
		verify_policy();
	endtask

	// Idle completion, all-ones and all-zeros requests, a full queue with a
	// dropped arrival, and selections with time and distance ties.
	task automatic run_directed();
		int i;
		send_item(completion(16'h0000));
		send_item(arrival(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
		send_item(arrival(16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 16'h0000));
		for (i = 1; i < DEPTH; i++) begin
			send_item(arrival(16'(i), (i % 3 == 0) ? 32'hFFFF_FFFF : 32'(i % 3),
				(i % 2 == 1) ? 16'd1000 + 16'(i % 4) : 16'd1000 - 16'(i % 4),
				{16'hA5A5, 16'(i)}, ~16'(i)));
		end
		send_item(arrival(16'h1234, 32'h0, 16'd1000, 32'h0BAD_0BAD, 16'h4321));
		send_item(completion(16'd1000));
		send_item(completion(16'd1000));
		settle();
		write_policy(POLICY_SSTF);
		send_item(completion(16'd1000));
		send_item(completion(16'd1002));
		send_item(completion(16'hFFFF));
	endtask

	initial begin
		int p;
		int n;
		int pct_tab[9];
		logic [CYL_W-1:0] center;
		pct_tab = '{60, 75, 90, 45, 80, 30, 70, 95, 20};
		mirror = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (p = 0; p < 9; p++) begin
			settle();
			if (p == 4) begin
				hold_cycles = 400;
			end
			write_policy(p[0]);
			if (p == 5) begin
				apb_write(REG_UNUSED, 32'hFFFF_FFFF);
				verify_policy();
			end
			sender_gaps = (p % 3 != 2);
			drain_gaps  = (p % 4 != 3);
			center      = rand16();
			stamp       = (p == 7) ? 32'hFFFF_FFC0 : $urandom;
			for (n = 0; n < 150; n++) begin
				send_item(random_item(pct_tab[p], p % 3, (p / 2) % 2, center));
			end
		end
		settle();
		if (mirror.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
